FILE: sv/kpa_pkg.sv
`default_nettype none

package kpa_pkg;

   // default build parameters
   localparam int KPA_COORD_BITS   = 10;
   localparam int KPA_CORDIC_STEPS = 16;

   // fixed field widths
   localparam int PIX_W   = 10;
   localparam int TURN_W  = 17;
   localparam int OUT_W   = 16;
   localparam int CSR_IDX_W = 1;

   // cordic formats
   localparam int PRESCALE  = 24;
   localparam int TABLE_LEN = 24;
   localparam int ATAN_W    = 22;
   localparam int ANG_W     = 26;

   // merge formats: difference, reduced, modulo 360, unsigned angle
   localparam int DIFF_W = 28;
   localparam int RED_W  = 27;
   localparam int MOD_W  = 25;
   localparam int ABS_W  = 24;

   // angles in 2^-16 degree; OUT_180 in 2^-8 degree
   localparam int DEG_90   = 90 * 65536;
   localparam int DEG_180  = 180 * 65536;
   localparam int DEG_360  = 360 * 65536;
   localparam int DEG_720  = 720 * 65536;
   localparam int DEG_1080 = 1080 * 65536;
   localparam int OUT_180  = 46080;
   localparam int ROUND_HALF = 128;
   localparam int ROUND_SHIFT = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SECOND = 1'b1;

   // register reset values
   localparam logic signed [TURN_W-1:0] TURN_FIRST_RESET  = -17'sd43817;
   localparam logic signed [TURN_W-1:0] TURN_SECOND_RESET = -17'sd13332;

   // atan(2^-i) in 2^-16 degree, rounded to nearest
   localparam logic [ATAN_W-1:0] ARCTAN_TAB [TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   // control that travels beside the data
   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;

endpackage

`default_nettype wire

FILE: sv/keypoint_pair_angles.sv
// keypoint_pair_angles: two angles from four pixel keypoints
//
// input: start with req_p1_x .. req_p4_y; an item is taken at every clock edge
// with start high and busy low. busy stays low, so one item can enter every
// cycle with no gaps.
// output: rsp_strobe is high for one cycle with rsp_zeta_angle, rsp_mu_angle
// and rsp_degenerate; the receiver cannot stall, results simply flow out.
// throughput: one item per clock. The pipeline is made of the two unrolled
// CORDIC lanes, one stage per rotation, plus an input stage, a fold stage
// and the five stages of the angle merge.
// config: csr_write_en, csr_index, csr_wdata write turn_first (index 0) and
// turn_second (index 1); write only while no item is in flight.
// reset: synchronous, clears the pipeline valid bits and loads the default
// turns; items in flight at reset are dropped.
`default_nettype none

module keypoint_pair_angles import kpa_pkg::*; #(
   parameter int COORD_BITS   = KPA_COORD_BITS,
   parameter int CORDIC_STEPS = KPA_CORDIC_STEPS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [PIX_W-1:0]     req_p1_x,
   input  wire logic [PIX_W-1:0]     req_p1_y,
   input  wire logic [PIX_W-1:0]     req_p2_x,
   input  wire logic [PIX_W-1:0]     req_p2_y,
   input  wire logic [PIX_W-1:0]     req_p3_x,
   input  wire logic [PIX_W-1:0]     req_p3_y,
   input  wire logic [PIX_W-1:0]     req_p4_x,
   input  wire logic [PIX_W-1:0]     req_p4_y,
   output logic                      rsp_strobe,
   output logic [OUT_W-1:0]          rsp_zeta_angle,
   output logic [OUT_W-1:0]          rsp_mu_angle,
   output logic                      rsp_degenerate,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TURN_W-1:0]    csr_wdata
);

   localparam int DW       = COORD_BITS + 1;
   localparam int NSTEP    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int LANE_LAT = NSTEP + 1;

   logic [COORD_BITS-1:0] c1x, c1y, c2x, c2y, c3x, c3y, c4x, c4y;
   logic signed [DW-1:0]  ax_c, ay_c, bx_c, by_c;
   logic                  degen_c;

   logic signed [DW-1:0]     ax_ff, ay_ff, bx_ff, by_ff;
   ctl_type                  ctl_ff [0:LANE_LAT];
   logic signed [TURN_W-1:0] turn_first_ff;
   logic signed [TURN_W-1:0] turn_second_ff;
   logic signed [ANG_W-1:0]  theta_a;
   logic signed [ANG_W-1:0]  theta_b;

   // fully pipelined, always ready
   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_first_ff  <= TURN_FIRST_RESET;
         turn_second_ff <= TURN_SECOND_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TURN_FIRST:  turn_first_ff  <= $signed(csr_wdata);
            CSR_TURN_SECOND: turn_second_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // coordinates cut to the used width, vectors with y pointing up
   always_comb begin
      c1x = COORD_BITS'(req_p1_x);
      c1y = COORD_BITS'(req_p1_y);
      c2x = COORD_BITS'(req_p2_x);
      c2y = COORD_BITS'(req_p2_y);
      c3x = COORD_BITS'(req_p3_x);
      c3y = COORD_BITS'(req_p3_y);
      c4x = COORD_BITS'(req_p4_x);
      c4y = COORD_BITS'(req_p4_y);
      ax_c = $signed(DW'(c2x) - DW'(c1x));
      ay_c = $signed(DW'(c1y) - DW'(c2y));
      bx_c = $signed(DW'(c4x) - DW'(c3x));
      by_c = $signed(DW'(c3y) - DW'(c4y));
      degen_c = ((ax_c == '0) && (ay_c == '0)) || ((bx_c == '0) && (by_c == '0));
   end

   // input stage
   always_ff @(posedge clock) begin
      ax_ff <= ax_c;
      ay_ff <= ay_c;
      bx_ff <= bx_c;
      by_ff <= by_c;
   end

   // control shift line matching the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LANE_LAT; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0].valid <= start && !busy;
         ctl_ff[0].degen <= degen_c;
         for (int k = 1; k <= LANE_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // one lane per vector
   kpa_cordic_lane #(
      .COORD_BITS   (COORD_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_lane_a (
      .clock (clock),
      .x_in  (ax_ff),
      .y_in  (ay_ff),
      .angle (theta_a)
   );

   kpa_cordic_lane #(
      .COORD_BITS   (COORD_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_lane_b (
      .clock (clock),
      .x_in  (bx_ff),
      .y_in  (by_ff),
      .angle (theta_b)
   );

   // differences, wrap and rounding
   kpa_angle_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .ctl_in         (ctl_ff[LANE_LAT]),
      .theta_a        (theta_a),
      .theta_b        (theta_b),
      .turn_first     (turn_first_ff),
      .turn_second    (turn_second_ff),
      .rsp_strobe     (rsp_strobe),
      .rsp_zeta_angle (rsp_zeta_angle),
      .rsp_mu_angle   (rsp_mu_angle),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

`default_nettype wire

FILE: sv/kpa_cordic_lane.sv
`default_nettype none

module kpa_cordic_lane import kpa_pkg::*; #(
   parameter int COORD_BITS   = KPA_COORD_BITS,
   parameter int CORDIC_STEPS = KPA_CORDIC_STEPS
) (
   input  wire logic                     clock,
   input  wire logic signed [COORD_BITS:0] x_in,
   input  wire logic signed [COORD_BITS:0] y_in,
   output logic signed [ANG_W-1:0]       angle
);

   localparam int DW    = COORD_BITS + 1;
   localparam int LW    = COORD_BITS + PRESCALE + 3;
   localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   logic                    neg;
   logic signed [DW-1:0]    xp;
   logic signed [DW-1:0]    yp;
   logic signed [ANG_W-1:0] z0;

   logic signed [LW-1:0]    x_ff [0:NSTEP-1];
   logic signed [LW-1:0]    y_ff [0:NSTEP-1];
   logic signed [ANG_W-1:0] z_ff [0:NSTEP];

   // fold left half plane into right half plane
   always_comb begin
      neg = x_in[DW-1];
      xp  = neg ? -x_in : x_in;
      yp  = neg ? -y_in : y_in;
      if (!neg) begin
         z0 = '0;
      end else if (!y_in[DW-1]) begin
         z0 = ANG_W'(DEG_180);
      end else begin
         z0 = -ANG_W'(DEG_180);
      end
   end

   // prescaled start vector
   always_ff @(posedge clock) begin
      x_ff[0] <= $signed({{(LW-DW-PRESCALE){xp[DW-1]}}, xp, {PRESCALE{1'b0}}});
      y_ff[0] <= $signed({{(LW-DW-PRESCALE){yp[DW-1]}}, yp, {PRESCALE{1'b0}}});
      z_ff[0] <= z0;
   end

   // one rotation per stage, driving y toward zero
   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic signed [ANG_W-1:0] atan_i;
      assign atan_i = $signed({{(ANG_W-ATAN_W){1'b0}}, ARCTAN_TAB[i]});

      always_ff @(posedge clock) begin
         if (!y_ff[i][LW-1]) begin
            z_ff[i+1] <= z_ff[i] + atan_i;
         end else begin
            z_ff[i+1] <= z_ff[i] - atan_i;
         end
      end

      if (i < NSTEP - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (!y_ff[i][LW-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            end
         end
      end
   end

   assign angle = z_ff[NSTEP];

endmodule

`default_nettype wire

FILE: sv/kpa_angle_merge.sv
`default_nettype none

module kpa_angle_merge import kpa_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_type                  ctl_in,
   input  wire logic signed [ANG_W-1:0]  theta_a,
   input  wire logic signed [ANG_W-1:0]  theta_b,
   input  wire logic signed [TURN_W-1:0] turn_first,
   input  wire logic signed [TURN_W-1:0] turn_second,
   output logic                          rsp_strobe,
   output logic [OUT_W-1:0]              rsp_zeta_angle,
   output logic [OUT_W-1:0]              rsp_mu_angle,
   output logic                          rsp_degenerate
);

   localparam int NANG = 2;

   ctl_type                  ctl_ff [0:3];
   logic signed [DIFF_W-1:0] d_ff   [NANG];
   logic [RED_W-1:0]         red_ff [NANG];
   logic [MOD_W-1:0]         mod_ff [NANG];
   logic [ABS_W-1:0]         abs_ff [NANG];
   logic [OUT_W-1:0]         sup    [NANG];

   logic                     strobe_ff;
   logic                     degen_ff;
   logic [OUT_W-1:0]         zeta_ff;
   logic [OUT_W-1:0]         mu_ff;

   logic signed [DIFF_W-1:0] tha_x;
   logic signed [DIFF_W-1:0] thb_x;
   logic signed [DIFF_W-1:0] turn1_x;
   logic signed [DIFF_W-1:0] turn2_x;

   // widen angles and turns to the difference format
   assign tha_x   = DIFF_W'(theta_a);
   assign thb_x   = DIFF_W'(theta_b);
   assign turn1_x = DIFF_W'($signed({turn_first, 8'b0}));
   assign turn2_x = DIFF_W'($signed({turn_second, 8'b0}));

   // control alongside the four merge stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < 4; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // turned direction minus reference direction
   always_ff @(posedge clock) begin
      d_ff[0] <= tha_x + turn1_x - DIFF_W'(DEG_90);
      d_ff[1] <= tha_x + turn2_x - thb_x;
   end

   for (genvar k = 0; k < NANG; k++) begin : g_ang
      logic [MOD_W-1:0]   mod_c;
      logic [ABS_W:0]     rnd;

      // bring into 0..1080 degrees
      always_ff @(posedge clock) begin
         if (d_ff[k][DIFF_W-1]) begin
            red_ff[k] <= RED_W'(d_ff[k] + DIFF_W'(DEG_1080));
         end else begin
            red_ff[k] <= RED_W'(d_ff[k]);
         end
      end

      // modulo 360 degrees
      always_ff @(posedge clock) begin
         if (red_ff[k] >= RED_W'(DEG_720)) begin
            mod_ff[k] <= MOD_W'(red_ff[k] - RED_W'(DEG_720));
         end else if (red_ff[k] >= RED_W'(DEG_360)) begin
            mod_ff[k] <= MOD_W'(red_ff[k] - RED_W'(DEG_360));
         end else begin
            mod_ff[k] <= MOD_W'(red_ff[k]);
         end
      end

      // unsigned angle, at most 180 degrees
      assign mod_c = MOD_W'(DEG_360) - mod_ff[k];
      always_ff @(posedge clock) begin
         abs_ff[k] <= (mod_ff[k] > mod_c) ? ABS_W'(mod_c) : ABS_W'(mod_ff[k]);
      end

      // round to 1/256 degree and take the supplement
      assign rnd    = {1'b0, abs_ff[k]} + (ABS_W+1)'(ROUND_HALF);
      assign sup[k] = OUT_W'(OUT_180) - OUT_W'(rnd >> ROUND_SHIFT);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_ff[3].valid;
      end
   end

   always_ff @(posedge clock) begin
      degen_ff <= ctl_ff[3].degen;
      zeta_ff  <= ctl_ff[3].degen ? '0 : sup[0];
      mu_ff    <= ctl_ff[3].degen ? '0 : sup[1];
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_zeta_angle = zeta_ff;
   assign rsp_mu_angle   = mu_ff;

endmodule

`default_nettype wire
